[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on clk, disabled in reset
`define SQA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication on clk, disabled in reset
`define SQA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/sqa_pkg.sv]
package sqa_pkg;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SCALE_MASK    = 3'd0;
  localparam cfg_idx_t CFG_SEMI_RANGE    = 3'd1;
  localparam cfg_idx_t CFG_SEMI_DIR      = 3'd2;
  localparam cfg_idx_t CFG_SEMI_CHANCE   = 3'd3;
  localparam cfg_idx_t CFG_OCT_RANGE     = 3'd4;
  localparam cfg_idx_t CFG_OCT_CHANCE    = 3'd5;
  localparam cfg_idx_t CFG_OCT_BOTH_WAYS = 3'd6;

  localparam logic [11:0] SCALE_MASK_RESET = 12'd2741;

  typedef enum logic [1:0] {
    DIR_DOWN   = 2'd0,
    DIR_BOUNCE = 2'd1,
    DIR_UP     = 2'd2,
    DIR_RANDOM = 2'd3
  } dir_t;

  typedef struct packed {
    logic [4:0] range;
    dir_t       dir;
    logic [6:0] chance;
  } arp_cfg_t;

  // roll hits when roll*100 < chance*65536
  function automatic logic roll_hit(input logic [15:0] roll, input logic [6:0] chance);
    logic [22:0] scaled;
    scaled = {7'd0, roll} * 23'd100;
    return scaled < {chance, 16'd0};
  endfunction

endpackage

[rtl/core/sqa_arp.sv]
`include "assert_macros.svh"

module sqa_arp
  import sqa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  arp_cfg_t    cfg,
  input  logic        adv,
  input  logic [6:0]  note,
  input  logic [15:0] roll,
  input  logic [15:0] draw,
  output logic [7:0]  note_sum
);

  logic [4:0]  step_r, step_nxt;
  logic        rising_r, rising_nxt;
  logic        hit;
  logic [5:0]  s_inc;
  logic [5:0]  range_p1;
  logic [21:0] rand_prod;

  assign hit       = (cfg.range != 5'd0) && (cfg.chance != 7'd0) && roll_hit(roll, cfg.chance);
  assign s_inc     = {1'b0, step_r} + 6'd1;
  assign range_p1  = {1'b0, cfg.range} + 6'd1;
  assign rand_prod = {6'd0, draw} * {16'd0, range_p1};

  always_comb begin
    step_nxt   = step_r;
    rising_nxt = rising_r;
    if (hit) begin
      unique case (cfg.dir)
        DIR_DOWN: begin
          step_nxt = (step_r == 5'd0) ? cfg.range : step_r - 5'd1;
        end
        DIR_BOUNCE: begin
          if (rising_r) begin
            if (s_inc >= {1'b0, cfg.range}) begin
              step_nxt   = cfg.range;
              rising_nxt = 1'b0;
            end else begin
              step_nxt = s_inc[4:0];
            end
          end else begin
            if (step_r <= 5'd1) begin
              step_nxt   = 5'd0;
              rising_nxt = 1'b1;
            end else begin
              step_nxt = step_r - 5'd1;
            end
          end
        end
        DIR_UP: begin
          step_nxt = (s_inc > {1'b0, cfg.range}) ? 5'd0 : s_inc[4:0];
        end
        DIR_RANDOM: begin
          step_nxt = rand_prod[20:16];
        end
        default: begin
          step_nxt = step_r;
        end
      endcase
    end
  end

  assign note_sum = hit ? ({1'b0, note} + {3'd0, step_nxt}) : {1'b0, note};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= 5'd0;
      rising_r <= 1'b1;
    end else if (adv) begin
      step_r   <= step_nxt;
      rising_r <= rising_nxt;
    end
  end

  `SQA_ASSERT_NEXT(a_step_holds_idle, !adv, $stable(step_r) && $stable(rising_r))
  `SQA_ASSERT_NEXT(a_rand_step_in_range, adv && hit && cfg.dir == DIR_RANDOM,
                   step_r <= $past(cfg.range))

endmodule

[rtl/core/sqa_quant.sv]
module sqa_quant
  import sqa_pkg::*;
(
  input  logic [7:0]        note,
  input  logic [11:0]       mask,
  input  logic signed [8:0] ofs,
  output logic [6:0]        note_out
);

  logic [15:0]       q_prod;
  logic [4:0]        q;
  logic [7:0]        base;
  logic [7:0]        diff;
  logic [3:0]        deg;
  logic [3:0]        best_d;
  logic [7:0]        qnote;
  logic signed [9:0] sum;

  // note / 12 by reciprocal, exact for every 8-bit note
  assign q_prod = {8'd0, note} * 16'd171;
  assign q      = q_prod[15:11];
  assign base   = {q[4:0], 3'd0} + {1'b0, q[4:0], 2'd0};
  assign diff   = note - base;
  assign deg    = diff[3:0];

  // nearest degree, smaller distance first, lower degree on a tie
  always_comb begin
    best_d = deg;
    for (int i = 11; i >= 1; i--) begin
      if ((int'(deg) + i <= 11) && mask[4'(int'(deg) + i)]) best_d = 4'(int'(deg) + i);
      if ((int'(deg) >= i) && mask[4'(int'(deg) - i)]) best_d = 4'(int'(deg) - i);
    end
  end

  assign qnote = (mask[deg] || mask == 12'd0) ? note : base + {4'd0, best_d};
  assign sum   = $signed({2'b00, qnote}) + 10'(ofs);

  always_comb begin
    if (sum < 10'sd0) begin
      note_out = 7'd0;
    end else if (sum > 10'sd127) begin
      note_out = 7'd127;
    end else begin
      note_out = sum[6:0];
    end
  end

endmodule

[rtl/core/scale_quantizer_with_arpeggio_core.sv]
// Scale quantizer with arpeggio: each transfer on the in_ channel yields exactly one note on
// the out_ channel, in order. A new note is taken every cycle while the output is being
// drained, and each note passes through three registers (input register, step register,
// result register); the rate is set by the arpeggio step and direction, which update once
// per note and feed the next note. Configuration writes on the cfg_ channel are always
// ready and take effect on the following cycle; indexes past the register list are
// ignored. No clearing pass is needed after reset.
`include "assert_macros.svh"

module scale_quantizer_with_arpeggio_core
  import sqa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [6:0]  in_note_in,
  input  logic [15:0] in_semitone_roll,
  input  logic [15:0] in_step_draw,
  input  logic [15:0] in_octave_roll,
  input  logic [15:0] in_octave_draw,
  input  logic        in_octave_sign_draw,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_note_out
);

  logic [11:0] scale_mask_r;
  logic [4:0]  semi_range_r;
  dir_t        semi_dir_r;
  logic [6:0]  semi_chance_r;
  logic [3:0]  oct_range_r;
  logic [6:0]  oct_chance_r;
  logic        oct_both_r;

  logic        s1_v_r;
  logic [6:0]  s1_note_r;
  logic [15:0] s1_sroll_r;
  logic [15:0] s1_sdraw_r;
  logic [15:0] s1_oroll_r;
  logic [15:0] s1_odraw_r;
  logic        s1_osign_r;

  logic              s2_v_r;
  logic [7:0]        s2_note_r, s2_note_nxt;
  logic signed [8:0] s2_ofs_r, s2_ofs_nxt;

  logic        out_valid_r;
  logic [6:0]  out_note_r, out_note_nxt;

  logic        out_adv, s2_adv, s1_adv;
  arp_cfg_t    arp_cfg;
  logic        oct_hit;
  logic [19:0] oct_prod;
  logic [4:0]  oct_amt;
  logic [7:0]  oct_mag;

  assign cfg_ready = 1'b1;

  assign out_adv  = !out_valid_r || out_ready;
  assign s2_adv   = !s2_v_r || out_adv;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_ready = s1_adv;

  assign out_valid    = out_valid_r;
  assign out_note_out = out_note_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mask_r  <= SCALE_MASK_RESET;
      semi_range_r  <= 5'd0;
      semi_dir_r    <= DIR_UP;
      semi_chance_r <= 7'd0;
      oct_range_r   <= 4'd0;
      oct_chance_r  <= 7'd0;
      oct_both_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SCALE_MASK:    scale_mask_r  <= cfg_data[11:0];
        CFG_SEMI_RANGE:    semi_range_r  <= cfg_data[4:0];
        CFG_SEMI_DIR:      semi_dir_r    <= dir_t'(cfg_data[1:0]);
        CFG_SEMI_CHANCE:   semi_chance_r <= cfg_data[6:0];
        CFG_OCT_RANGE:     oct_range_r   <= cfg_data[3:0];
        CFG_OCT_CHANCE:    oct_chance_r  <= cfg_data[6:0];
        CFG_OCT_BOTH_WAYS: oct_both_r    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign arp_cfg.range  = semi_range_r;
  assign arp_cfg.dir    = semi_dir_r;
  assign arp_cfg.chance = semi_chance_r;

  sqa_arp u_arp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (arp_cfg),
    .adv      (s1_v_r && s2_adv),
    .note     (s1_note_r),
    .roll     (s1_sroll_r),
    .draw     (s1_sdraw_r),
    .note_sum (s2_note_nxt)
  );

  // octave shift of 1..range octaves
  assign oct_hit  = (oct_range_r != 4'd0) && (oct_chance_r != 7'd0)
                    && roll_hit(s1_oroll_r, oct_chance_r);
  assign oct_prod = {4'd0, s1_odraw_r} * {16'd0, oct_range_r};
  assign oct_amt  = {1'b0, oct_prod[19:16]} + 5'd1;
  assign oct_mag  = {oct_amt, 3'd0} + {1'b0, oct_amt, 2'd0};

  always_comb begin
    if (!oct_hit) begin
      s2_ofs_nxt = 9'sd0;
    end else if (oct_both_r && s1_osign_r) begin
      s2_ofs_nxt = -$signed({1'b0, oct_mag});
    end else begin
      s2_ofs_nxt = $signed({1'b0, oct_mag});
    end
  end

  sqa_quant u_quant (
    .note     (s2_note_r),
    .mask     (scale_mask_r),
    .ofs      (s2_ofs_r),
    .note_out (out_note_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) s1_v_r <= in_valid;
      if (s2_adv) s2_v_r <= s1_v_r;
      if (out_adv) out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_adv) begin
      s1_note_r  <= in_note_in;
      s1_sroll_r <= in_semitone_roll;
      s1_sdraw_r <= in_step_draw;
      s1_oroll_r <= in_octave_roll;
      s1_odraw_r <= in_octave_draw;
      s1_osign_r <= in_octave_sign_draw;
    end
    if (s1_v_r && s2_adv) begin
      s2_note_r <= s2_note_nxt;
      s2_ofs_r  <= s2_ofs_nxt;
    end
    if (s2_v_r && out_adv) begin
      out_note_r <= out_note_nxt;
    end
  end

  `SQA_ASSERT_IMPL(a_empty_output_takes_input, !out_valid_r, in_ready)
  `SQA_ASSERT_IMPL(a_result_from_mid_stage, $rose(out_valid_r), $past(s2_v_r))

endmodule
